### sv/sgr_pkg.sv
// Shared types, constants and font lookup for the scaled glyph rectangle renderer.
package sgr_pkg;

  localparam int SCREEN_WIDTH_DEF  = 240;
  localparam int SCREEN_HEIGHT_DEF = 240;
  localparam int BURST_ROWS_DEF    = 20;

  localparam int COORD_W     = 16;
  localparam int GLYPH_COLS  = 5;
  localparam int GLYPH_ROWS  = 7;
  localparam int GLYPH_BITS  = GLYPH_COLS * GLYPH_ROWS;
  localparam int H_MAX       = GLYPH_ROWS * 15;
  localparam int QUEUE_DEPTH = 2;
  localparam int SPACE_INDEX = 31;

  localparam logic [2:0] LAST_ROW   = 3'(GLYPH_ROWS - 1);
  localparam logic [2:0] SPACER_COL = 3'(GLYPH_COLS);

  typedef struct packed {
    logic [GLYPH_BITS-1:0] glyph;
    logic signed [11:0]    px;
    logic signed [11:0]    py;
    logic [3:0]            scale;
    logic [15:0]           fg;
    logic [15:0]           bg;
  } glyph_rec_t;

  function automatic logic [4:0] glyph_index(input logic [7:0] code);
    logic [4:0] idx;
    case (code) inside
      ["0":"9"]: idx = 5'(code - 8'h30);
      "A":       idx = 5'd10;
      "B":       idx = 5'd11;
      "D":       idx = 5'd12;
      "E":       idx = 5'd13;
      "F":       idx = 5'd14;
      "G":       idx = 5'd15;
      "H":       idx = 5'd16;
      "I":       idx = 5'd17;
      "L":       idx = 5'd18;
      "M":       idx = 5'd19;
      "N":       idx = 5'd20;
      "O":       idx = 5'd21;
      "P":       idx = 5'd22;
      "R":       idx = 5'd23;
      "S":       idx = 5'd24;
      "T":       idx = 5'd25;
      "U":       idx = 5'd26;
      "Y":       idx = 5'd27;
      ":":       idx = 5'd28;
      "-":       idx = 5'd29;
      ".":       idx = 5'd30;
      default:   idx = 5'(SPACE_INDEX);
    endcase
    return idx;
  endfunction

  // Column 0 sits in the top byte, bit 0 of each byte is the top row.
  function automatic logic [39:0] font_columns(input logic [4:0] idx);
    logic [39:0] f;
    case (idx)
      5'd0:    f = 40'h3E_51_49_45_3E;
      5'd1:    f = 40'h00_42_7F_40_00;
      5'd2:    f = 40'h42_61_51_49_46;
      5'd3:    f = 40'h21_41_45_4B_31;
      5'd4:    f = 40'h18_14_12_7F_10;
      5'd5:    f = 40'h27_45_45_45_39;
      5'd6:    f = 40'h3C_4A_49_49_30;
      5'd7:    f = 40'h01_71_09_05_03;
      5'd8:    f = 40'h36_49_49_49_36;
      5'd9:    f = 40'h06_49_49_29_1E;
      5'd10:   f = 40'h7E_11_11_11_7E;
      5'd11:   f = 40'h7F_49_49_49_36;
      5'd12:   f = 40'h7F_41_41_22_1C;
      5'd13:   f = 40'h7F_49_49_49_41;
      5'd14:   f = 40'h7F_09_09_09_01;
      5'd15:   f = 40'h3E_41_49_49_7A;
      5'd16:   f = 40'h7F_08_08_08_7F;
      5'd17:   f = 40'h00_41_7F_41_00;
      5'd18:   f = 40'h7F_40_40_40_40;
      5'd19:   f = 40'h7F_02_04_02_7F;
      5'd20:   f = 40'h7F_04_08_10_7F;
      5'd21:   f = 40'h3E_41_41_41_3E;
      5'd22:   f = 40'h7F_09_09_09_06;
      5'd23:   f = 40'h7F_09_19_29_46;
      5'd24:   f = 40'h46_49_49_49_31;
      5'd25:   f = 40'h01_01_7F_01_01;
      5'd26:   f = 40'h3F_40_40_40_3F;
      5'd27:   f = 40'h07_08_70_08_07;
      5'd28:   f = 40'h00_36_36_00_00;
      5'd29:   f = 40'h08_08_08_08_08;
      5'd30:   f = 40'h00_60_60_00_00;
      default: f = 40'h00_00_00_00_00;
    endcase
    return f;
  endfunction

  // Dots in column-major order: bit col*7+row.
  function automatic logic [GLYPH_BITS-1:0] glyph_bits(input logic [7:0] code);
    logic [39:0]           f;
    logic [GLYPH_BITS-1:0] b;
    f = font_columns(glyph_index(code));
    for (int c = 0; c < GLYPH_COLS; c++) begin
      for (int r = 0; r < GLYPH_ROWS; r++) begin
        b[c*GLYPH_ROWS + r] = f[32 - 8*c + r];
      end
    end
    return b;
  endfunction

endpackage

### sv/sgr_front.sv
// Front end: accepts a character item, looks up its glyph and hands it to the queue.
module sgr_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [7:0]         in_char_code,
  input  logic signed [11:0] in_pos_x,
  input  logic signed [11:0] in_pos_y,
  input  logic [3:0]         in_scale,
  input  logic [15:0]        in_fg_color,
  input  logic [15:0]        in_bg_color,
  input  logic               q_full,
  output logic               push,
  output sgr_pkg::glyph_rec_t push_data
);
  import sgr_pkg::*;

  logic       vld_r;
  glyph_rec_t rec_r;
  logic       accept;

  assign busy   = vld_r && q_full;
  assign accept = start && !busy;
  assign push   = vld_r && !q_full;
  assign push_data = rec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (accept) begin
      vld_r <= 1'b1;
    end else if (push) begin
      vld_r <= 1'b0;
    end
    if (accept) begin
      rec_r.glyph <= glyph_bits(in_char_code);
      rec_r.px    <= in_pos_x;
      rec_r.py    <= in_pos_y;
      rec_r.scale <= in_scale;
      rec_r.fg    <= in_fg_color;
      rec_r.bg    <= in_bg_color;
    end
  end

endmodule

### sv/sgr_queue.sv
// Short queue of looked-up character items between the front end and the rectangle stepper.
module sgr_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  sgr_pkg::glyph_rec_t push_data,
  output logic                full,
  input  logic                pop,
  output sgr_pkg::glyph_rec_t pop_data,
  output logic                empty
);
  import sgr_pkg::*;

  localparam int ADDR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

  glyph_rec_t        mem_r [QUEUE_DEPTH];
  logic [ADDR_W-1:0] wr_ptr_r;
  logic [ADDR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0]  cnt_r;

  assign full     = cnt_r == CNT_W'(QUEUE_DEPTH);
  assign empty    = cnt_r == '0;
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ADDR_W'(wr_ptr_r + 1'b1);
      end
      if (pop) begin
        rd_ptr_r <= ADDR_W'(rd_ptr_r + 1'b1);
      end
      if (push && !pop) begin
        cnt_r <= CNT_W'(cnt_r + 1'b1);
      end else if (pop && !push) begin
        cnt_r <= CNT_W'(cnt_r - 1'b1);
      end
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### sv/sgr_back.sv
// Back end: steps through the 36 rectangles of a character, clips them and counts bursts.
module sgr_back #(
  parameter int SCREEN_WIDTH  = sgr_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = sgr_pkg::SCREEN_HEIGHT_DEF,
  parameter int BURST_ROWS    = sgr_pkg::BURST_ROWS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  sgr_pkg::glyph_rec_t q_data,
  output logic                pop,
  output logic                out_strobe,
  output logic                out_visible,
  output logic [7:0]          out_win_x,
  output logic [7:0]          out_win_y,
  output logic [3:0]          out_win_w,
  output logic [6:0]          out_win_h,
  output logic [15:0]         out_fill_color,
  output logic [2:0]          out_burst_count,
  output logic                out_last
);
  import sgr_pkg::*;

  localparam int BURST_K = 20;
  localparam int RECIP   = (2**BURST_K + BURST_ROWS - 1) / BURST_ROWS;
  localparam int RECIP_W = BURST_K + 1;
  localparam int NUM_W   = $clog2(H_MAX + BURST_ROWS);

  typedef struct packed {
    logic        vld;
    logic        vis;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [3:0]  w;
    logic [6:0]  h;
    logic [15:0] color;
    logic        last;
  } clip_t;

  logic                      active_r;
  glyph_rec_t                rec_r;
  logic [2:0]                row_r;
  logic [2:0]                col_r;
  logic [5:0]                bit_r;
  logic signed [COORD_W-1:0] x_r;
  logic signed [COORD_W-1:0] y_r;
  clip_t                     st1_r;

  logic                      spacer;
  logic signed [COORD_W-1:0] s_ext;
  logic signed [COORD_W-1:0] py_ext;
  logic [6:0]                h7;
  clip_t                     st1_nxt;
  logic [NUM_W-1:0]          num;
  logic [NUM_W+RECIP_W-1:0]  prod;

  assign spacer = col_r == SPACER_COL;
  assign pop    = !q_empty && (!active_r || spacer);
  assign s_ext  = {{(COORD_W-4){1'b0}}, rec_r.scale};
  assign py_ext = {{(COORD_W-12){rec_r.py[11]}}, rec_r.py};
  assign h7     = 7'({rec_r.scale, 3'b000} - {3'b000, rec_r.scale});

  always_comb begin
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] cw;
    logic signed [COORD_W-1:0] ch;
    logic signed [COORD_W-1:0] sw;
    logic signed [COORD_W-1:0] sh;
    logic                      vis;
    sw  = COORD_W'(SCREEN_WIDTH);
    sh  = COORD_W'(SCREEN_HEIGHT);
    cx  = x_r;
    cy  = y_r;
    cw  = s_ext;
    ch  = spacer ? {{(COORD_W-7){1'b0}}, h7} : s_ext;
    vis = 1'b0;
    if (cw > 0 && ch > 0) begin
      if (cx < 0) begin
        cw = cw + cx;
        cx = '0;
      end
      if (cy < 0) begin
        ch = ch + cy;
        cy = '0;
      end
      if (cx + cw > sw) begin
        cw = sw - cx;
      end
      if (cy + ch > sh) begin
        ch = sh - cy;
      end
      vis = cw > 0 && ch > 0;
    end
    if (!vis) begin
      cx = '0;
      cy = '0;
      cw = '0;
      ch = '0;
    end
    st1_nxt.vld   = active_r;
    st1_nxt.vis   = vis;
    st1_nxt.x     = cx[7:0];
    st1_nxt.y     = cy[7:0];
    st1_nxt.w     = cw[3:0];
    st1_nxt.h     = ch[6:0];
    st1_nxt.color = (!spacer && rec_r.glyph[bit_r]) ? rec_r.fg : rec_r.bg;
    st1_nxt.last  = spacer;
  end

  assign num  = NUM_W'(st1_r.h) + NUM_W'(BURST_ROWS - 1);
  assign prod = (NUM_W+RECIP_W)'(num) * (NUM_W+RECIP_W)'(RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r   <= 1'b0;
      st1_r.vld  <= 1'b0;
      out_strobe <= 1'b0;
    end else begin
      if (pop) begin
        active_r <= 1'b1;
      end else if (spacer) begin
        active_r <= 1'b0;
      end
      st1_r.vld  <= st1_nxt.vld;
      out_strobe <= st1_r.vld;
    end
    if (pop) begin
      rec_r <= q_data;
      x_r   <= {{(COORD_W-12){q_data.px[11]}}, q_data.px};
      y_r   <= {{(COORD_W-12){q_data.py[11]}}, q_data.py};
      row_r <= '0;
      col_r <= '0;
      bit_r <= '0;
    end else if (active_r && !spacer) begin
      bit_r <= 6'(bit_r + 1'b1);
      if (row_r == LAST_ROW) begin
        row_r <= '0;
        col_r <= 3'(col_r + 1'b1);
        x_r   <= x_r + s_ext;
        y_r   <= py_ext;
      end else begin
        row_r <= 3'(row_r + 1'b1);
        y_r   <= y_r + s_ext;
      end
    end
    st1_r.vis   <= st1_nxt.vis;
    st1_r.x     <= st1_nxt.x;
    st1_r.y     <= st1_nxt.y;
    st1_r.w     <= st1_nxt.w;
    st1_r.h     <= st1_nxt.h;
    st1_r.color <= st1_nxt.color;
    st1_r.last  <= st1_nxt.last;
    out_visible     <= st1_r.vis;
    out_win_x       <= st1_r.x;
    out_win_y       <= st1_r.y;
    out_win_w       <= st1_r.w;
    out_win_h       <= st1_r.h;
    out_fill_color  <= st1_r.color;
    out_burst_count <= prod[BURST_K +: 3];
    out_last        <= st1_r.last && st1_r.vld;
  end

endmodule

### sv/scaled_glyph_rect_renderer_top.sv
// Top level of the scaled glyph rectangle renderer: front end, item queue and rectangle stepper.
// Each character item yields 36 rectangles, one per clock cycle; the back-end stepper walks the
// 35 font dots in column-major order and then the spacer column. An accepted item passes the
// front-end register, the queue and the stepper, clip and output registers, and the rectangles of
// consecutive items follow without a gap while the next item is already queued. An item is
// accepted when start is high and busy is low; busy rises only when the two-entry queue and the
// front-end register are both full. Results carry no back-pressure: each is valid for the single
// cycle in which out_strobe is high, and out_last marks the spacer, the last of the 36.
module scaled_glyph_rect_renderer_top #(
  parameter int SCREEN_WIDTH  = sgr_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = sgr_pkg::SCREEN_HEIGHT_DEF,
  parameter int BURST_ROWS    = sgr_pkg::BURST_ROWS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [7:0]         in_char_code,
  input  logic signed [11:0] in_pos_x,
  input  logic signed [11:0] in_pos_y,
  input  logic [3:0]         in_scale,
  input  logic [15:0]        in_fg_color,
  input  logic [15:0]        in_bg_color,
  output logic               out_strobe,
  output logic               out_visible,
  output logic [7:0]         out_win_x,
  output logic [7:0]         out_win_y,
  output logic [3:0]         out_win_w,
  output logic [6:0]         out_win_h,
  output logic [15:0]        out_fill_color,
  output logic [2:0]         out_burst_count,
  output logic               out_last
);
  import sgr_pkg::*;

  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_empty;
  glyph_rec_t q_in;
  glyph_rec_t q_out;

  sgr_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_char_code (in_char_code),
    .in_pos_x     (in_pos_x),
    .in_pos_y     (in_pos_y),
    .in_scale     (in_scale),
    .in_fg_color  (in_fg_color),
    .in_bg_color  (in_bg_color),
    .q_full       (q_full),
    .push         (q_push),
    .push_data    (q_in)
  );

  sgr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  sgr_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .BURST_ROWS    (BURST_ROWS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_data          (q_out),
    .pop             (q_pop),
    .out_strobe      (out_strobe),
    .out_visible     (out_visible),
    .out_win_x       (out_win_x),
    .out_win_y       (out_win_y),
    .out_win_w       (out_win_w),
    .out_win_h       (out_win_h),
    .out_fill_color  (out_fill_color),
    .out_burst_count (out_burst_count),
    .out_last        (out_last)
  );

  a_clipped_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_visible) |->
      (out_win_w == 4'd0 && out_win_h == 7'd0 && out_burst_count == 3'd0))
    else $error("fully clipped rectangle carries geometry");

  a_visible_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_visible) |-> (out_win_w != 4'd0 && out_win_h != 7'd0))
    else $error("visible rectangle is empty");

  a_last_strobed: assert property (@(posedge clk) disable iff (!rst_n)
    out_last |-> out_strobe)
    else $error("last flag without a result");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("queue popped while empty");

endmodule

### dv/tb_top.sv
// Self-checking testbench for the scaled glyph rectangle renderer: predicts all 36 rectangles.
module tb_top;

  localparam int SCR_W      = sgr_pkg::SCREEN_WIDTH_DEF;
  localparam int SCR_H      = sgr_pkg::SCREEN_HEIGHT_DEF;
  localparam int BURST      = sgr_pkg::BURST_ROWS_DEF;
  localparam int N_COLS     = 5;
  localparam int N_ROWS     = 7;
  localparam int BLANK_SLOT = 31;
  localparam int COLON_SLOT = 28;
  localparam int DASH_SLOT  = 29;
  localparam int DOT_SLOT   = 30;
  localparam int LETTER_0   = 10;
  localparam int N_LETTERS  = 18;

  localparam bit [7:0] FONT [32][5] = '{
    '{8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E}, '{8'h00, 8'h42, 8'h7F, 8'h40, 8'h00},
    '{8'h42, 8'h61, 8'h51, 8'h49, 8'h46}, '{8'h21, 8'h41, 8'h45, 8'h4B, 8'h31},
    '{8'h18, 8'h14, 8'h12, 8'h7F, 8'h10}, '{8'h27, 8'h45, 8'h45, 8'h45, 8'h39},
    '{8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30}, '{8'h01, 8'h71, 8'h09, 8'h05, 8'h03},
    '{8'h36, 8'h49, 8'h49, 8'h49, 8'h36}, '{8'h06, 8'h49, 8'h49, 8'h29, 8'h1E},
    '{8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E}, '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h36},
    '{8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C}, '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h41},
    '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h01}, '{8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A},
    '{8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F}, '{8'h00, 8'h41, 8'h7F, 8'h41, 8'h00},
    '{8'h7F, 8'h40, 8'h40, 8'h40, 8'h40}, '{8'h7F, 8'h02, 8'h04, 8'h02, 8'h7F},
    '{8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F}, '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E},
    '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h06}, '{8'h7F, 8'h09, 8'h19, 8'h29, 8'h46},
    '{8'h46, 8'h49, 8'h49, 8'h49, 8'h31}, '{8'h01, 8'h01, 8'h7F, 8'h01, 8'h01},
    '{8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F}, '{8'h07, 8'h08, 8'h70, 8'h08, 8'h07},
    '{8'h00, 8'h36, 8'h36, 8'h00, 8'h00}, '{8'h08, 8'h08, 8'h08, 8'h08, 8'h08},
    '{8'h00, 8'h60, 8'h60, 8'h00, 8'h00}, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  localparam bit [7:0] LETTERS [N_LETTERS] = '{
    "A", "B", "D", "E", "F", "G", "H", "I", "L",
    "M", "N", "O", "P", "R", "S", "T", "U", "Y"
  };

  typedef struct packed {
    bit        visible;
    bit [7:0]  x;
    bit [7:0]  y;
    bit [3:0]  w;
    bit [6:0]  h;
    bit [15:0] color;
    bit [2:0]  bursts;
    bit        last;
  } rect_t;

  function automatic int slot_of_code(bit [7:0] code);
    if (code >= "0" && code <= "9") return int'(code) - int'("0");
    for (int i = 0; i < N_LETTERS; i++) begin
      if (code == LETTERS[i]) return LETTER_0 + i;
    end
    if (code == ":") return COLON_SLOT;
    if (code == "-") return DASH_SLOT;
    if (code == ".") return DOT_SLOT;
    return BLANK_SLOT;
  endfunction

  function automatic bit [7:0] code_of_slot(int slot);
    if (slot < LETTER_0) return 8'("0" + slot);
    if (slot < COLON_SLOT) return LETTERS[slot - LETTER_0];
    if (slot == COLON_SLOT) return ":";
    if (slot == DASH_SLOT) return "-";
    if (slot == DOT_SLOT) return ".";
    return " ";
  endfunction

  class glyph_rect_scoreboard;
    rect_t pending_rects[$];
    int    fault_count = 0;

    function rect_t clip_rect(int x, int y, int w, int h, bit [15:0] color, bit last);
      rect_t r;
      bit    vis;
      vis = 1'b0;
      if (w > 0 && h > 0) begin
        if (x < 0) begin
          w += x;
          x = 0;
        end
        if (y < 0) begin
          h += y;
          y = 0;
        end
        if (x + w > SCR_W) w = SCR_W - x;
        if (y + h > SCR_H) h = SCR_H - y;
        vis = (w > 0 && h > 0);
      end
      if (!vis) begin
        x = 0;
        y = 0;
        w = 0;
        h = 0;
      end
      r.visible = vis;
      r.x       = x[7:0];
      r.y       = y[7:0];
      r.w       = w[3:0];
      r.h       = h[6:0];
      r.color   = color;
      r.bursts  = 3'((h + BURST - 1) / BURST);
      r.last    = last;
      return r;
    endfunction

    function void note_char(bit [7:0] code, int px, int py, int s, bit [15:0] fg,
                            bit [15:0] bg);
      int       slot;
      bit [7:0] line;
      slot = slot_of_code(code);
      for (int c = 0; c < N_COLS; c++) begin
        line = FONT[slot][c];
        for (int r = 0; r < N_ROWS; r++) begin
          pending_rects.push_back(clip_rect(px + c * s, py + r * s, s, s,
                                            line[r] ? fg : bg, 1'b0));
        end
      end
      pending_rects.push_back(clip_rect(px + N_COLS * s, py, s, N_ROWS * s, bg, 1'b1));
    endfunction

    function void compare(string field, int exp_v, int act_v);
      if (exp_v != act_v) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
        fault_count++;
      end
    endfunction

    function void check_rect(rect_t got);
      rect_t exp_r;
      if (pending_rects.size() == 0) begin
        $display("%0t: unexpected rectangle, expected none, actual %h", $time, got);
        fault_count++;
        return;
      end
      exp_r = pending_rects.pop_front();
      compare("visible", exp_r.visible, got.visible);
      compare("win_x", exp_r.x, got.x);
      compare("win_y", exp_r.y, got.y);
      compare("win_w", exp_r.w, got.w);
      compare("win_h", exp_r.h, got.h);
      compare("fill_color", exp_r.color, got.color);
      compare("burst_count", exp_r.bursts, got.bursts);
      compare("last", exp_r.last, got.last);
    endfunction

    function int pending();
      return pending_rects.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [7:0]        in_char_code = '0;
  logic signed [11:0] in_pos_x = '0;
  logic signed [11:0] in_pos_y = '0;
  logic [3:0]        in_scale = '0;
  logic [15:0]       in_fg_color = '0;
  logic [15:0]       in_bg_color = '0;
  logic              out_strobe;
  logic              out_visible;
  logic [7:0]        out_win_x;
  logic [7:0]        out_win_y;
  logic [3:0]        out_win_w;
  logic [6:0]        out_win_h;
  logic [15:0]       out_fill_color;
  logic [2:0]        out_burst_count;
  logic              out_last;

  glyph_rect_scoreboard sb = new();

  scaled_glyph_rect_renderer_top i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_char_code   (in_char_code),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_scale       (in_scale),
    .in_fg_color    (in_fg_color),
    .in_bg_color    (in_bg_color),
    .out_strobe     (out_strobe),
    .out_visible    (out_visible),
    .out_win_x      (out_win_x),
    .out_win_y      (out_win_y),
    .out_win_w      (out_win_w),
    .out_win_h      (out_win_h),
    .out_fill_color (out_fill_color),
    .out_burst_count(out_burst_count),
    .out_last       (out_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      sb.note_char(in_char_code, in_pos_x, in_pos_y, in_scale, in_fg_color, in_bg_color);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      sb.check_rect(rect_t'({out_visible, out_win_x, out_win_y, out_win_w, out_win_h,
                             out_fill_color, out_burst_count, out_last}));
    end
  end

  task automatic send_char(bit [7:0] code, int px, int py, bit [3:0] s, bit [15:0] fg,
                           bit [15:0] bg);
    in_char_code <= code;
    in_pos_x     <= 12'(px);
    in_pos_y     <= 12'(py);
    in_scale     <= s;
    in_fg_color  <= fg;
    in_bg_color  <= bg;
    start        <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic hold_off(int idle_pct);
    while (int'($urandom_range(99)) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic int random_pos();
    case ($urandom_range(9))
      0, 1:    return int'($urandom_range(4095)) - 2048;
      2:       return int'($urandom_range(40)) - 30;
      3:       return int'($urandom_range(60)) + 200;
      default: return int'($urandom_range(250)) - 10;
    endcase
  endfunction

  task automatic send_random_char(int idle_pct);
    bit [7:0] code;
    int       px;
    int       py;
    hold_off(idle_pct);
    if ($urandom_range(3) != 0) code = code_of_slot($urandom_range(DOT_SLOT));
    else code = 8'($urandom_range(255));
    px = random_pos();
    py = random_pos();
    send_char(code, px, py, 4'($urandom_range(15)), 16'($urandom_range(65535)),
              16'($urandom_range(65535)));
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed corners: unknown codes, zero scale, full and partial clipping, maximum scale.
    send_char("0", 0, 0, 4'd1, 16'hFFFF, 16'h0000);
    send_char("A", 10, 20, 4'd3, 16'h0000, 16'hFFFF);
    send_char("Z", 50, 50, 4'd2, 16'h1234, 16'hFEDC);
    send_char(8'd255, 60, 30, 4'd4, 16'hAAAA, 16'h5555);
    send_char(8'd128, 80, 90, 4'd2, 16'h5555, 16'hAAAA);
    send_char(8'd0, 5, 5, 4'd1, 16'hF800, 16'h07E0);
    send_char("8", 100, 100, 4'd0, 16'hFFFF, 16'h001F);
    send_char("8", -2048, -2048, 4'd15, 16'hFFFF, 16'h0000);
    send_char("8", 2047, 2047, 4'd15, 16'h0000, 16'hFFFF);
    send_char("M", -7, -7, 4'd4, 16'h7BEF, 16'h8410);
    send_char("H", 230, 230, 4'd5, 16'hFFE0, 16'h001F);
    send_char("B", 0, 0, 4'd15, 16'hFFFF, 16'h0000);
    send_char("W", 165, 135, 4'd15, 16'h0F0F, 16'hF0F0);
    send_char("8", 165, 135, 4'd15, 16'hF0F0, 16'h0F0F);
    send_char(".", 239, 239, 4'd1, 16'hFFFF, 16'hFFFF);
    send_char("1", -1, 0, 4'd1, 16'h0001, 16'h8000);
    send_char("1", 240, 0, 4'd1, 16'h8000, 16'h0001);
    send_char("E", 0, -105, 4'd15, 16'h3333, 16'hCCCC);
    send_char(":", -2048, 2047, 4'd7, 16'h00FF, 16'hFF00);
    send_char("-", 2047, -2048, 4'd8, 16'hFF00, 16'h00FF);
    send_char("Y", -30, 226, 4'd6, 16'hFFFF, 16'h0000);
    send_char("T", 226, -30, 4'd6, 16'h0000, 16'hFFFF);
    wait_drained();

    repeat (90) send_random_char(0);
    wait_drained();
    repeat (90) send_random_char(86);
    wait_drained();
    repeat (90) send_random_char(14);
    wait_drained();

    repeat (40) @(posedge clk);
    if (sb.fault_count == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
